### hw/rtl/kidt_pkg.sv
`default_nettype none

package kidt_pkg;

  localparam int unsigned TableSlots = 64;
  localparam int unsigned SlotAddrW  = $clog2(TableSlots);
  localparam int unsigned ScanCntW   = SlotAddrW + 1;
  localparam int unsigned EvictCntW  = $clog2(TableSlots + 1);
  localparam int unsigned EvictOutW  = 7;
  localparam int unsigned EvictMax   = 127;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic {
    MODE_ADD    = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] group_id;
    logic [30:0]        seq_num;
    logic signed [31:0] entry_key;
    logic [30:0]        age_limit;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic signed [31:0] group_id;
    logic signed [31:0] entry_key;
    logic [30:0]        seq_num;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } back_state_e;

endpackage

`default_nettype wire

### hw/rtl/kidt_ram.sv
`default_nettype none

module kidt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kidt_front.sv
`default_nettype none

module kidt_front
  import kidt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output queue_head_t head_o
);

  item_t                buf_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = buf_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kidt_back.sv
`default_nettype none

module kidt_back
  import kidt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire queue_head_t  head_i,
  output logic              pop_o,
  output logic              result_valid_o,
  output logic signed [31:0] found_seq_o,
  output logic [EvictOutW-1:0] evicted_count_o,
  output logic              table_full_o
);

  back_state_e          state_q, state_d;
  item_t                cur_q, cur_d;
  logic [ScanCntW-1:0]  cnt_q, cnt_d;
  logic [TableSlots-1:0] valid_q, valid_d;
  logic signed [31:0]   newest_q, newest_d;

  logic                 grp_seen_q, grp_seen_d;
  logic                 pair_hit_q, pair_hit_d;
  logic [SlotAddrW-1:0] pair_idx_q, pair_idx_d;
  logic [30:0]          pair_seq_q, pair_seq_d;
  logic                 pair_evict_q, pair_evict_d;
  logic                 free_hit_q, free_hit_d;
  logic [SlotAddrW-1:0] free_idx_q, free_idx_d;
  logic [EvictCntW-1:0] evict_q, evict_d;

  logic                 res_valid_q, res_valid_d;
  logic signed [31:0]   found_q, found_d;
  logic [EvictOutW-1:0] evicted_q, evicted_d;
  logic                 full_q, full_d;

  logic                 rd_en;
  logic [SlotAddrW-1:0] rd_addr;
  slot_t                rd_slot;
  logic                 wr_en;
  logic [SlotAddrW-1:0] wr_addr;
  slot_t                wr_slot;

  logic [SlotAddrW-1:0] data_idx;
  logic                 data_live;
  logic                 slot_v;
  logic                 grp_match;
  logic                 pair_match;
  logic signed [32:0]   evict_diff;
  logic                 evict_hit;
  logic signed [32:0]   look_diff;
  logic                 do_insert;
  logic [EvictCntW-1:0] evict_adj;
  logic [31:0]          evict_wide;

  kidt_ram #(
    .WIDTH (SlotW),
    .DEPTH (TableSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_slot),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_slot)
  );

  assign rd_addr   = cnt_q[SlotAddrW-1:0];
  assign data_idx  = SlotAddrW'(cnt_q - 1'b1);
  assign data_live = (state_q == ST_SCAN) && (cnt_q != '0);
  assign slot_v    = valid_q[data_idx];
  assign grp_match = data_live && slot_v && (rd_slot.group_id == cur_q.group_id);
  assign pair_match = grp_match && (rd_slot.entry_key == cur_q.entry_key);
  assign evict_diff = $signed({2'b00, cur_q.seq_num}) - $signed({2'b00, rd_slot.seq_num});
  assign evict_hit  = grp_match && (cur_q.mode == MODE_ADD) &&
                      (evict_diff > $signed({2'b00, cur_q.age_limit}));
  assign look_diff  = $signed({newest_q[31], newest_q}) - $signed({2'b00, pair_seq_q});
  assign do_insert  = !grp_seen_q || !cur_q.entry_key[31];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == ScanCntW'(TableSlots)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = pair_hit_q ? pair_idx_q : free_idx_q;
    wr_slot.group_id  = cur_q.group_id;
    wr_slot.entry_key = cur_q.entry_key;
    wr_slot.seq_num   = cur_q.seq_num;

    cur_d        = cur_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    newest_d     = newest_q;
    grp_seen_d   = grp_seen_q;
    pair_hit_d   = pair_hit_q;
    pair_idx_d   = pair_idx_q;
    pair_seq_d   = pair_seq_q;
    pair_evict_d = pair_evict_q;
    free_hit_d   = free_hit_q;
    free_idx_d   = free_idx_q;
    evict_d      = evict_q;
    res_valid_d  = 1'b0;
    found_d      = found_q;
    evicted_d    = evicted_q;
    full_d       = full_q;
    evict_adj    = evict_q;
    evict_wide   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o        = 1'b1;
          cur_d        = head_i.item;
          cnt_d        = '0;
          grp_seen_d   = 1'b0;
          pair_hit_d   = 1'b0;
          pair_evict_d = 1'b0;
          free_hit_d   = 1'b0;
          evict_d      = '0;
        end
      end
      ST_SCAN: begin
        rd_en = (cnt_q < ScanCntW'(TableSlots));
        cnt_d = cnt_q + 1'b1;
        if (grp_match) begin
          grp_seen_d = 1'b1;
        end
        if (pair_match && !pair_hit_q) begin
          pair_hit_d   = 1'b1;
          pair_idx_d   = data_idx;
          pair_seq_d   = rd_slot.seq_num;
          pair_evict_d = evict_hit;
        end
        if (data_live && !slot_v && !free_hit_q) begin
          free_hit_d = 1'b1;
          free_idx_d = data_idx;
        end
        if (evict_hit) begin
          valid_d[data_idx] = 1'b0;
          evict_d = evict_q + 1'b1;
        end
      end
      ST_FINISH: begin
        res_valid_d = 1'b1;
        if (cur_q.mode == MODE_ADD) begin
          found_d = '0;
          full_d  = 1'b0;
          if ($signed({1'b0, cur_q.seq_num}) > newest_q) begin
            newest_d = $signed({1'b0, cur_q.seq_num});
          end
          if (do_insert) begin
            if (pair_hit_q || free_hit_q) begin
              wr_en            = 1'b1;
              valid_d[wr_addr] = 1'b1;
            end else begin
              full_d = 1'b1;
            end
          end
          if (do_insert && pair_hit_q && pair_evict_q) begin
            evict_adj = evict_q - 1'b1;
          end
          evict_wide = 32'(evict_adj);
          evicted_d  = (evict_wide > 32'(EvictMax)) ? EvictOutW'(EvictMax)
                                                    : evict_wide[EvictOutW-1:0];
        end else begin
          evicted_d = '0;
          full_d    = 1'b0;
          if (pair_hit_q && (look_diff < $signed({2'b00, cur_q.age_limit}))) begin
            found_d = $signed({1'b0, pair_seq_q});
          end else begin
            found_d = '1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      newest_q    <= '1;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      newest_q    <= newest_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    grp_seen_q   <= grp_seen_d;
    pair_hit_q   <= pair_hit_d;
    pair_idx_q   <= pair_idx_d;
    pair_seq_q   <= pair_seq_d;
    pair_evict_q <= pair_evict_d;
    free_hit_q   <= free_hit_d;
    free_idx_q   <= free_idx_d;
    evict_q      <= evict_d;
    found_q      <= found_d;
    evicted_q    <= evicted_d;
    full_q       <= full_d;
  end

  assign result_valid_o  = res_valid_q;
  assign found_seq_o     = found_q;
  assign evicted_count_o = evicted_q;
  assign table_full_o    = full_q;

endmodule

`default_nettype wire

### hw/rtl/keyed_id_table_with_age_expiry_top.sv
`default_nettype none

// Keyed sequence-number table with age expiry.
// An item is presented on mode_i, group_id_i, seq_num_i, entry_key_i and
// age_limit_i and is taken on a clock edge where start is high and busy is low.
// A two-entry queue holds taken items; busy is high only while that queue is full.
// The table engine walks all 64 slots of its slot RAM once per item, one slot per
// cycle through the RAM read port, looking up the pair, the first free slot and
// the group, and evicting aged entries of the group on an add as it goes.
// Each item passes through the engine's idle, scan and finish states, and its
// result beat is registered from the finish state that follows the walk. The
// engine takes the next item from the queue only once it is idle again.
// Each result beat is shown for exactly one cycle with result_valid_o high and
// must be taken then; the receiver cannot stall the block.
// Reset empties the queue, marks every slot free and sets the newest sequence
// number to minus one; no clearing pass is needed.
module keyed_id_table_with_age_expiry_top
  import kidt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode_i,
  input  wire logic signed [31:0] group_id_i,
  input  wire logic [30:0]        seq_num_i,
  input  wire logic signed [31:0] entry_key_i,
  input  wire logic [30:0]        age_limit_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      found_seq_o,
  output logic [EvictOutW-1:0]    evicted_count_o,
  output logic                    table_full_o
);

  item_t       in_item;
  queue_head_t head;
  logic        pop;

  assign in_item.mode      = mode_e'(mode_i);
  assign in_item.group_id  = group_id_i;
  assign in_item.seq_num   = seq_num_i;
  assign in_item.entry_key = entry_key_i;
  assign in_item.age_limit = age_limit_i;

  kidt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start),
    .item_i (in_item),
    .full_o (busy),
    .pop_i  (pop),
    .head_o (head)
  );

  kidt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .result_valid_o  (result_valid_o),
    .found_seq_o     (found_seq_o),
    .evicted_count_o (evicted_count_o),
    .table_full_o    (table_full_o)
  );

endmodule

`default_nettype wire
